// File: rtl/rpp_pkg.sv
package rpp_pkg;

	// Result kinds carried on tuser
	localparam logic RES_ENTRY   = 1'b0;
	localparam logic RES_VERDICT = 1'b1;

	localparam int MAX_ENTRIES_DEFAULT = 25;
	localparam int QUEUE_DEPTH         = 4;
	localparam int OUT_DATA_W          = 144;

	// Packet layout constants
	localparam logic [15:0] IDX_IHL      = 16'd0;
	localparam logic [15:0] IDX_LEN_HI   = 16'd2;
	localparam logic [15:0] IDX_LEN_LO   = 16'd3;
	localparam logic [15:0] IDX_BODY     = 16'd4;
	localparam logic [6:0]  UDP_HDR_LEN  = 7'd8;
	localparam logic [6:0]  MIN_TAIL_LEN = 7'd12;
	localparam logic [4:0]  ENTRY_LAST   = 5'd19;
	localparam logic [7:0]  CMD_REQUEST  = 8'd1;
	localparam logic [7:0]  CMD_RESPONSE = 8'd2;
	localparam logic [7:0]  RIP_VER_EXP  = 8'd2;
	localparam logic [7:0]  FAMILY_INET  = 8'd2;
	localparam logic [31:0] METRIC_MAX   = 32'd16;

	typedef struct packed {
		logic        kind;
		logic [31:0] addr;
		logic [31:0] mask;
		logic [31:0] next_hop;
		logic [31:0] metric;
		logic [7:0]  cmd;
		logic [4:0]  count;
		logic        valid;
		logic        last;
	} result_t;

	function automatic logic mask_ok(input logic [31:0] m);
		logic [31:0] inv;
		inv = ~m;
		return (inv & (inv + 32'd1)) == 32'd0;
	endfunction

endpackage

// File: rtl/rpp_parser.sv
module rpp_parser #(
	parameter int MAX_ENTRIES = rpp_pkg::MAX_ENTRIES_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       pkt_byte,
	input  logic             last_byte,
	output logic [1:0]       res_num,
	output rpp_pkg::result_t res0,
	output rpp_pkg::result_t res1
);

	localparam logic [4:0] MAX_CNT = 5'(MAX_ENTRIES);

	logic [15:0] byte_index_q, byte_index_n;
	logic [5:0]  ihl_bytes_q, ihl_bytes_n;
	logic [15:0] decl_len_q, decl_len_n;
	logic [7:0]  cmd_q, cmd_n;
	logic [4:0]  ent_pos_q, ent_pos_n;
	logic [31:0] fields_q [4];
	logic [31:0] fields_n [4];
	logic [4:0]  entries_q, entries_n;
	logic        err_q, err_n;

	always_comb begin
		logic [6:0]  start;
		logic [15:0] rel;
		logic [4:0]  pos_off;
		logic [16:0] received;
		logic        emit_entry;
		logic        verdict_ok;
		rpp_pkg::result_t ent_res;
		rpp_pkg::result_t ver_res;

		byte_index_n = byte_index_q;
		ihl_bytes_n  = ihl_bytes_q;
		decl_len_n   = decl_len_q;
		cmd_n        = cmd_q;
		ent_pos_n    = ent_pos_q;
		fields_n     = fields_q;
		entries_n    = entries_q;
		err_n        = err_q;
		emit_entry   = 1'b0;
		start        = {1'b0, ihl_bytes_q} + rpp_pkg::UDP_HDR_LEN;
		rel          = byte_index_q - {9'd0, start};
		pos_off      = ent_pos_q - 5'd4;

		if (accept) begin
			if (byte_index_q == rpp_pkg::IDX_IHL) begin
				ihl_bytes_n = {pkt_byte[3:0], 2'b00};
			end else if (byte_index_q == rpp_pkg::IDX_LEN_HI) begin
				decl_len_n = {pkt_byte, decl_len_q[7:0]};
			end else if (byte_index_q == rpp_pkg::IDX_LEN_LO) begin
				decl_len_n = {decl_len_q[15:8], pkt_byte};
			end else if (byte_index_q >= rpp_pkg::IDX_BODY && byte_index_q < decl_len_q
					&& byte_index_q >= {9'd0, start}) begin
				if (rel == 16'd0) begin
					cmd_n = pkt_byte;
					if (pkt_byte != rpp_pkg::CMD_REQUEST && pkt_byte != rpp_pkg::CMD_RESPONSE)
						err_n = 1'b1;
				end else if (rel == 16'd1) begin
					if (pkt_byte != rpp_pkg::RIP_VER_EXP)
						err_n = 1'b1;
				end else if (rel < 16'd4) begin
					if (pkt_byte != 8'd0)
						err_n = 1'b1;
				end else begin
					if (ent_pos_q == 5'd1) begin
						// family must match the command
						if (pkt_byte != ((cmd_q == rpp_pkg::CMD_RESPONSE) ?
								rpp_pkg::FAMILY_INET : 8'd0))
							err_n = 1'b1;
					end else if (ent_pos_q < 5'd4) begin
						if (pkt_byte != 8'd0)
							err_n = 1'b1;
					end else begin
						fields_n[pos_off[3:2]] = {fields_q[pos_off[3:2]][23:0], pkt_byte};
					end
					if (ent_pos_q >= rpp_pkg::ENTRY_LAST) begin
						ent_pos_n = 5'd0;
						if (!rpp_pkg::mask_ok(fields_n[1]))
							err_n = 1'b1;
						if (fields_n[3] < 32'd1 || fields_n[3] > rpp_pkg::METRIC_MAX)
							err_n = 1'b1;
						if (entries_q >= MAX_CNT) begin
							err_n = 1'b1;
						end else begin
							entries_n  = entries_q + 5'd1;
							emit_entry = 1'b1;
						end
					end else begin
						ent_pos_n = ent_pos_q + 5'd1;
					end
				end
			end
			if (byte_index_q != 16'hFFFF)
				byte_index_n = byte_index_q + 16'd1;
		end

		received   = {1'b0, byte_index_q} + 17'd1;
		verdict_ok = !err_n && received >= 17'd4 && {1'b0, decl_len_n} <= received
			&& decl_len_n >= {9'd0, {1'b0, ihl_bytes_n} + rpp_pkg::MIN_TAIL_LEN};

		ent_res.kind     = rpp_pkg::RES_ENTRY;
		ent_res.addr     = fields_n[0];
		ent_res.mask     = fields_n[1];
		ent_res.next_hop = fields_n[2];
		ent_res.metric   = fields_n[3];
		ent_res.cmd      = cmd_n;
		ent_res.count    = entries_n;
		ent_res.valid    = !err_n;
		ent_res.last     = !last_byte;

		ver_res.kind     = rpp_pkg::RES_VERDICT;
		ver_res.addr     = 32'd0;
		ver_res.mask     = 32'd0;
		ver_res.next_hop = 32'd0;
		ver_res.metric   = 32'd0;
		ver_res.cmd      = cmd_n;
		ver_res.count    = entries_n;
		ver_res.valid    = verdict_ok;
		ver_res.last     = 1'b1;

		res0    = emit_entry ? ent_res : ver_res;
		res1    = ver_res;
		res_num = accept ? ({1'b0, emit_entry} + {1'b0, last_byte}) : 2'd0;

		// drop the packet state after the verdict; the entry field words are kept
		if (accept && last_byte) begin
			byte_index_n = 16'd0;
			ihl_bytes_n  = 6'd0;
			decl_len_n   = 16'd0;
			cmd_n        = 8'd0;
			ent_pos_n    = 5'd0;
			entries_n    = 5'd0;
			err_n        = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			ihl_bytes_q  <= '0;
			decl_len_q   <= '0;
			cmd_q        <= '0;
			ent_pos_q    <= '0;
			entries_q    <= '0;
			err_q        <= 1'b0;
		end else begin
			byte_index_q <= byte_index_n;
			ihl_bytes_q  <= ihl_bytes_n;
			decl_len_q   <= decl_len_n;
			cmd_q        <= cmd_n;
			ent_pos_q    <= ent_pos_n;
			entries_q    <= entries_n;
			err_q        <= err_n;
		end
	end

	always_ff @(posedge clk) begin
		fields_q <= fields_n;
	end

endmodule

// File: rtl/rpp_result_queue.sv
module rpp_result_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       push_num,
	input  rpp_pkg::result_t push0,
	input  rpp_pkg::result_t push1,
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output rpp_pkg::result_t out_res
);

	localparam int DEPTH = rpp_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	rpp_pkg::result_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          pop;
	logic [PW-1:0] wr_ptr_p1;

	assign pop       = out_valid && out_ready;
	assign out_valid = count_q != '0;
	assign out_res   = mem_q[rd_ptr_q];
	// hold off new bytes unless two result slots are free
	assign room      = count_q <= CW'(DEPTH - 2);
	assign wr_ptr_p1 = wr_ptr_q + PW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push_num);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			count_q <= count_q + CW'(push_num) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_num != 2'd0)
			mem_q[wr_ptr_q] <= push0;
		if (push_num == 2'd2)
			mem_q[wr_ptr_p1] <= push1;
	end

endmodule

// File: rtl/ripv2_packet_parser_top.sv
// RIPv2 packet parser.
// Slave stream: one IPv4/UDP/RIPv2 packet byte per request on s_axis_tdata,
// s_axis_tlast on the final byte received. The IP and UDP headers are
// skipped, the RIP header and each 20-byte route entry are checked, and
// checksums are ignored. Bytes past the IP total length are discarded.
// Master stream: tuser 0 carries a completed route entry, tuser 1 the
// end-of-packet verdict; tlast marks the last result caused by one byte.
// A result is written into the result queue when the byte that completes
// it is accepted. Throughput: one byte per cycle while s_axis_tready is high;
// a byte that both closes an entry and ends the packet yields two results,
// which leave the master side one after the other.
// Results go through a four-entry queue. s_axis_tready is high while at
// least two slots are free, so a stalled receiver holds off the slave side
// once three results are waiting; nothing is dropped.
// Reset clears the parse state and the queue; the next byte starts a packet.
module ripv2_packet_parser_top #(
	parameter int MAX_ENTRIES = rpp_pkg::MAX_ENTRIES_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,  // packet_byte
	input  logic                           s_axis_tlast,  // last_byte
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// route_addr, route_mask, route_next_hop, route_metric, rip_cmd,
	// entry_count, packet_valid, zero pad
	output logic [rpp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                           m_axis_tuser,  // result_kind
	output logic                           m_axis_tlast   // run_last
);

	logic             accept;
	logic [1:0]       res_num;
	rpp_pkg::result_t res0, res1, out_res;

	assign accept = s_axis_tvalid && s_axis_tready;

	rpp_parser #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.pkt_byte (s_axis_tdata),
		.last_byte(s_axis_tlast),
		.res_num  (res_num),
		.res0     (res0),
		.res1     (res1)
	);

	rpp_result_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_num (res_num),
		.push0    (res0),
		.push1    (res1),
		.room     (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_res  (out_res)
	);

	assign m_axis_tdata = {2'b00, out_res.valid, out_res.count, out_res.cmd,
		out_res.metric, out_res.next_hop, out_res.mask, out_res.addr};
	assign m_axis_tuser = out_res.kind;
	assign m_axis_tlast = out_res.last;

endmodule

// File: bench/ripv2_packet_parser_top_test.sv
`timescale 1ns / 100ps

module ripv2_packet_parser_top_test;

	localparam int ROUTE_LIMIT     = rpp_pkg::MAX_ENTRIES_DEFAULT;
	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int HOLD_OFF_CYCLES = 400;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       typed;
		logic [7:0] cmd;
		logic [4:0] count;
		logic       ok;
	} stim_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [7:0]                     s_axis_tdata;
	logic                           s_axis_tlast;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;
	logic [rpp_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic                           m_axis_tuser;
	logic                           m_axis_tlast;

	// Parser state as the block should hold it
	logic [15:0] pos_in_packet;
	logic [5:0]  ihl_bytes;
	logic [15:0] decl_length;
	logic [7:0]  cmd_seen;
	logic [4:0]  entry_pos;
	logic [31:0] entry_word [4];
	logic [4:0]  entry_total;
	logic        parse_error;

	rpp_pkg::result_t step_res [2];
	rpp_pkg::result_t pending_results [$];
	rpp_pkg::result_t seen_result;
	rpp_pkg::result_t due_result;
	logic [7:0] packet_buf [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_off_asked = 0;
	int hold_off_taken = 0;
	int hold_left = 0;
	int cycle_count = 0;
	int error_count = 0;
	int results_predicted = 0;
	int entries_checked = 0;
	int verdicts_checked = 0;
	int bytes_sent = 0;
	int packets_sent = 0;

	// Short packets, a minimal valid packet, a too-small length with an
	// ignored trailing byte, and a truncated packet
	stim_row_t directed_rows [25] = '{
		'{8'hFF, 1'b1, 1'b1, 8'h00, 5'd0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0},
		'{8'h00, 1'b1, 1'b1, 8'h00, 5'd0, 1'b0},
		'{8'h40, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0},
		'{8'h0C, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0},
		'{8'hAA, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0},
		'{8'h55, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0},
		'{rpp_pkg::CMD_RESPONSE, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0},
		'{rpp_pkg::RIP_VER_EXP, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0},
		'{8'h00, 1'b1, 1'b1, rpp_pkg::CMD_RESPONSE, 5'd0, 1'b1},
		'{8'h45, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0},
		'{8'h04, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0},
		'{8'h01, 1'b1, 1'b1, 8'h00, 5'd0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 8'h00, 5'd0, 1'b0},
		'{8'hFF, 1'b1, 1'b1, 8'h00, 5'd0, 1'b0}
	};

	ripv2_packet_parser_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic start_new_packet();
		pos_in_packet = '0;
		ihl_bytes     = '0;
		decl_length   = '0;
		cmd_seen      = '0;
		entry_pos     = '0;
		entry_word    = '{default: '0};
		entry_total   = '0;
		parse_error   = 1'b0;
	endtask

	function automatic rpp_pkg::result_t make_result(input logic kind,
			input logic [4:0] count, input logic ok);
		rpp_pkg::result_t r;
		r = '0;
		r.kind = kind;
		if (kind == rpp_pkg::RES_ENTRY) begin
			r.addr     = entry_word[0];
			r.mask     = entry_word[1];
			r.next_hop = entry_word[2];
			r.metric   = entry_word[3];
		end
		r.cmd   = cmd_seen;
		r.count = count;
		r.valid = ok;
		return r;
	endfunction

	// Advance the parser by one byte; results land in step_res[0..n-1]
	task automatic parse_byte(input logic [7:0] b, input logic l, output int n);
		logic [15:0] idx;
		logic [7:0]  want;
		int          rip_off;
		int          k;
		int          received;
		logic        ok;
		n = 0;
		idx = pos_in_packet;
		if (idx == rpp_pkg::IDX_IHL) begin
			ihl_bytes = {b[3:0], 2'b00};
		end else if (idx == rpp_pkg::IDX_LEN_HI) begin
			decl_length[15:8] = b;
		end else if (idx == rpp_pkg::IDX_LEN_LO) begin
			decl_length[7:0] = b;
		end else if (idx >= rpp_pkg::IDX_BODY && idx < decl_length
				&& int'(idx) >= int'(ihl_bytes) + int'(rpp_pkg::UDP_HDR_LEN)) begin
			rip_off = int'(idx) - int'(ihl_bytes) - int'(rpp_pkg::UDP_HDR_LEN);
			if (rip_off == 0) begin
				cmd_seen = b;
				if (b != rpp_pkg::CMD_REQUEST && b != rpp_pkg::CMD_RESPONSE)
					parse_error = 1'b1;
			end else if (rip_off == 1) begin
				if (b != rpp_pkg::RIP_VER_EXP)
					parse_error = 1'b1;
			end else if (rip_off < 4) begin
				if (b != 8'h00)
					parse_error = 1'b1;
			end else begin
				if (entry_pos < 2) begin
					want = (entry_pos == 1 && cmd_seen == rpp_pkg::CMD_RESPONSE) ?
						rpp_pkg::FAMILY_INET : 8'h00;
					if (b != want)
						parse_error = 1'b1;
				end else if (entry_pos < 4) begin
					if (b != 8'h00)
						parse_error = 1'b1;
				end else begin
					k = (int'(entry_pos) - 4) >> 2;
					entry_word[k] = {entry_word[k][23:0], b};
				end
				if (entry_pos == rpp_pkg::ENTRY_LAST) begin
					entry_pos = '0;
					// a good mask is all ones from the top, as many as it has ones
					if (entry_word[1] != ~(32'hFFFF_FFFF >> $countones(entry_word[1])))
						parse_error = 1'b1;
					if (entry_word[3] < 32'd1 || entry_word[3] > rpp_pkg::METRIC_MAX)
						parse_error = 1'b1;
					if (int'(entry_total) >= ROUTE_LIMIT) begin
						parse_error = 1'b1;
					end else begin
						entry_total = entry_total + 5'd1;
						step_res[n] = make_result(rpp_pkg::RES_ENTRY, entry_total,
							!parse_error);
						n++;
					end
				end else begin
					entry_pos = entry_pos + 5'd1;
				end
			end
		end
		if (pos_in_packet != 16'hFFFF)
			pos_in_packet = pos_in_packet + 16'd1;
		if (l) begin
			received = int'(idx) + 1;
			ok = !parse_error && received >= 4 && int'(decl_length) <= received
				&& int'(decl_length) >= int'(ihl_bytes) + int'(rpp_pkg::MIN_TAIL_LEN);
			step_res[n] = make_result(rpp_pkg::RES_VERDICT, entry_total, ok);
			n++;
			start_new_packet();
		end
		if (n > 0)
			step_res[n - 1].last = 1'b1;
	endtask

	task automatic queue_step(input int n);
		for (int j = 0; j < n; j++)
			pending_results.push_back(step_res[j]);
		results_predicted += n;
	endtask

	// Offer one byte from a falling edge; return at the falling edge after acceptance
	task automatic push_byte(input logic [7:0] b, input logic l, output int n);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= l;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		parse_byte(b, l, n);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	function automatic logic [7:0] flawed(input logic [7:0] good, input int pct);
		return ($urandom_range(0, 99) < pct) ? 8'($urandom_range(0, 255)) : good;
	endfunction

	task automatic push_word(input logic [31:0] w);
		for (int j = 3; j >= 0; j--)
			packet_buf.push_back(w[8*j +: 8]);
	endtask

	task automatic build_packet(input int entry_n, input int pad_n, input bit well_formed,
			output int counted);
		int          shape;
		int          bad_pct;
		int          ihb;
		int          img_len;
		int          declared;
		int          keep;
		int          r;
		int          prefix;
		logic [3:0]  ihl;
		logic [3:0]  ver_nibble;
		logic [7:0]  cmd;
		logic [15:0] decl16;
		logic [31:0] mask;
		logic [31:0] metric;
		packet_buf.delete();
		shape = well_formed ? 0 : $urandom_range(0, 99);
		if (shape >= 93) begin
			// noise of random length
			r = $urandom_range(1, 40);
			repeat (r) packet_buf.push_back(8'($urandom_range(0, 255)));
			counted = r;
			return;
		end
		bad_pct = (shape >= 70 && shape < 85) ? 12 : 0;
		case ($urandom_range(0, 3))
			0: ihl = 4'd0;
			1: ihl = 4'($urandom_range(0, 15));
			default: ihl = 4'd5;
		endcase
		ihb = int'(ihl) * 4;
		ver_nibble = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'h4;
		packet_buf.push_back({ver_nibble, ihl});
		packet_buf.push_back(8'($urandom_range(0, 255)));
		packet_buf.push_back(8'h00);
		packet_buf.push_back(8'h00);
		while (packet_buf.size() < ihb + int'(rpp_pkg::UDP_HDR_LEN))
			packet_buf.push_back(8'($urandom_range(0, 255)));
		cmd = ($urandom_range(0, 99) < bad_pct) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(rpp_pkg::CMD_REQUEST, rpp_pkg::CMD_RESPONSE));
		packet_buf.push_back(cmd);
		packet_buf.push_back(flawed(rpp_pkg::RIP_VER_EXP, bad_pct));
		packet_buf.push_back(flawed(8'h00, bad_pct));
		packet_buf.push_back(flawed(8'h00, bad_pct));
		for (int e = 0; e < entry_n; e++) begin
			packet_buf.push_back(flawed(8'h00, bad_pct));
			packet_buf.push_back(flawed(cmd == rpp_pkg::CMD_RESPONSE ?
				rpp_pkg::FAMILY_INET : 8'h00, bad_pct));
			packet_buf.push_back(flawed(8'h00, bad_pct));
			packet_buf.push_back(flawed(8'h00, bad_pct));
			push_word($urandom);
			prefix = $urandom_range(0, 32);
			mask = ~(32'hFFFF_FFFF >> prefix);
			if ($urandom_range(0, 99) < bad_pct)
				mask = $urandom;
			push_word(mask);
			push_word($urandom);
			metric = $urandom_range(1, 16);
			if ($urandom_range(0, 99) < bad_pct) begin
				case ($urandom_range(0, 2))
					0: metric = 32'd0;
					1: metric = rpp_pkg::METRIC_MAX + 32'd1;
					default: metric = $urandom;
				endcase
			end
			push_word(metric);
		end
		img_len = packet_buf.size();
		declared = img_len;
		keep = img_len;
		if (shape >= 85) begin
			case ($urandom_range(0, 3))
				0: declared = img_len + $urandom_range(1, 30);
				1: begin
					// partial entry inside the declared length
					r = $urandom_range(1, 19);
					repeat (r) packet_buf.push_back(8'($urandom_range(0, 255)));
					declared = packet_buf.size();
				end
				2: declared = $urandom_range(0, ihb + int'(rpp_pkg::MIN_TAIL_LEN) - 1);
				default: keep = $urandom_range(1, img_len - 1);
			endcase
		end else if ($urandom_range(0, 4) == 0) begin
			pad_n += $urandom_range(1, 12);
		end
		decl16 = 16'(declared);
		packet_buf[2] = decl16[15:8];
		packet_buf[3] = decl16[7:0];
		while (packet_buf.size() > keep)
			void'(packet_buf.pop_back());
		repeat (pad_n) packet_buf.push_back(8'($urandom_range(0, 255)));
		if (declared < packet_buf.size())
			counted = (declared > 4) ? declared : 4;
		else
			counted = packet_buf.size();
	endtask

	task automatic send_packet();
		int n;
		for (int j = 0; j < packet_buf.size(); j++) begin
			push_byte(packet_buf[j], j == packet_buf.size() - 1, n);
			queue_step(n);
		end
		packets_sent++;
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct, input int byte_goal,
			input int result_goal);
		int phase_bytes;
		int counted;
		int entry_n;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		phase_bytes = 0;
		while (phase_bytes < byte_goal || results_predicted < result_goal) begin
			entry_n = ($urandom_range(0, 19) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
			build_packet(entry_n, 0, 1'b0, counted);
			send_packet();
			phase_bytes += counted;
		end
		settle();
	endtask

	initial begin
		int               n;
		int               counted;
		rpp_pkg::result_t typed;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'h00;
		s_axis_tlast  = 1'b0;
		start_new_packet();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 30;
		recv_idle_pct = 55;
		foreach (directed_rows[i]) begin
			push_byte(directed_rows[i].data, directed_rows[i].last, n);
			if (directed_rows[i].typed) begin
				typed       = '0;
				typed.kind  = rpp_pkg::RES_VERDICT;
				typed.cmd   = directed_rows[i].cmd;
				typed.count = directed_rows[i].count;
				typed.valid = directed_rows[i].ok;
				typed.last  = 1'b1;
				pending_results.push_back(typed);
				results_predicted++;
			end else begin
				queue_step(n);
			end
		end
		settle();

		run_phase(30, 55, 80, 0);
		// hold the receiver off while requests keep coming
		hold_off_asked++;
		run_phase(55, 30, 120, 0);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		build_packet(ROUTE_LIMIT + 2, 0, 1'b1, counted);
		send_packet();
		run_phase(0, 0, 40, 60);

		repeat (20) @(negedge clk);
		$display("%0d packets, %0d bytes sent; %0d route entries and %0d verdicts checked",
			packets_sent, bytes_sent, entries_checked, verdicts_checked);
		$display("included entry overflow, short and truncated packets and a %0d-cycle %s",
			HOLD_OFF_CYCLES, "receiver hold-off");
		if (error_count == 0)
			$display("ripv2_packet_parser_top_test: clean");
		else
			$display("ripv2_packet_parser_top_test: errors");
		$finish;
	end

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_asked != hold_off_taken) begin
				hold_off_taken = hold_off_asked;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %0h, actual %0h", $time, name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen_result          = '0;
			seen_result.kind     = m_axis_tuser;
			seen_result.addr     = m_axis_tdata[31:0];
			seen_result.mask     = m_axis_tdata[63:32];
			seen_result.next_hop = m_axis_tdata[95:64];
			seen_result.metric   = m_axis_tdata[127:96];
			seen_result.cmd      = m_axis_tdata[135:128];
			seen_result.count    = m_axis_tdata[140:136];
			seen_result.valid    = m_axis_tdata[141];
			seen_result.last     = m_axis_tlast;
			if (pending_results.size() == 0) begin
				$display("%0t ns: result with none expected, kind %0d count %0d",
					$time, seen_result.kind, seen_result.count);
				error_count++;
			end else begin
				due_result = pending_results.pop_front();
				check_field("result_kind", due_result.kind, seen_result.kind);
				check_field("route_addr", due_result.addr, seen_result.addr);
				check_field("route_mask", due_result.mask, seen_result.mask);
				check_field("route_next_hop", due_result.next_hop, seen_result.next_hop);
				check_field("route_metric", due_result.metric, seen_result.metric);
				check_field("rip_cmd", due_result.cmd, seen_result.cmd);
				check_field("entry_count", due_result.count, seen_result.count);
				check_field("packet_valid", due_result.valid, seen_result.valid);
				check_field("run_last", due_result.last, seen_result.last);
				if (due_result.kind == rpp_pkg::RES_ENTRY)
					entries_checked++;
				else
					verdicts_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("ripv2_packet_parser_top_test: errors");
			$finish;
		end
	end

endmodule
